[rtl/apt_pkg.sv]
`default_nettype none

package apt_pkg;

    // Width of every unsigned Q0.16 operand (gains, time step, step limit).
    localparam int MULT_BITS = 16;

    // Thrust values in Q0.16.
    localparam logic [15:0] HOVER_Q16      = 16'd32768;
    localparam logic [15:0] THRUST_MIN_Q16 = 16'd9830;
    localparam logic [15:0] THRUST_MAX_Q16 = 16'd55706;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RUN_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_P_GAIN           = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_I_GAIN           = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_D_GAIN           = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUIET_BAND       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEP         = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTEGRATOR_LIMIT = 3'd6;
    localparam int CFG_DATA_BITS = 31;

    // Register values after reset.
    localparam logic [15:0] P_GAIN_RST           = 16'd1311;
    localparam logic [15:0] I_GAIN_RST           = 16'd131;
    localparam logic [15:0] D_GAIN_RST           = 16'd5243;
    localparam logic [30:0] QUIET_BAND_RST       = 31'd32768;
    localparam logic [15:0] MAX_STEP_RST         = 16'd5243;
    localparam logic [30:0] INTEGRATOR_LIMIT_RST = 31'd327680;

    // Current register contents as seen by the datapath.
    typedef struct packed {
        logic        run_enable;
        logic [15:0] p_gain;
        logic [15:0] i_gain;
        logic [15:0] d_gain;
        logic [30:0] quiet_band;
        logic [15:0] max_step;
        logic [30:0] integrator_limit;
    } cfg_t;

    // Serial multiplier sequencer.
    typedef enum logic [3:0] {
        MUL_IDLE = 4'b0001,
        MUL_RUN  = 4'b0010,
        MUL_RND  = 4'b0100,
        MUL_SGN  = 4'b1000
    } mul_state_t;

    // Controller sequencer.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_START = 8'b0000_0100,
        ST_WAIT1 = 8'b0000_1000,
        ST_CLAMP = 8'b0001_0000,
        ST_WAIT2 = 8'b0010_0000,
        ST_SLEW  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

[rtl/apt_cfg_regs.sv]
`default_nettype none

module apt_cfg_regs
    import apt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wen,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                          cfg,
    output logic                          integ_clear
);

    cfg_t cfg_reg, cfg_next;

    // Decode a write into the addressed register; unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_RUN_ENABLE:       cfg_next.run_enable       = cfg_wdata[0];
                REG_P_GAIN:           cfg_next.p_gain           = cfg_wdata[15:0];
                REG_I_GAIN:           cfg_next.i_gain           = cfg_wdata[15:0];
                REG_D_GAIN:           cfg_next.d_gain           = cfg_wdata[15:0];
                REG_QUIET_BAND:       cfg_next.quiet_band       = cfg_wdata[30:0];
                REG_MAX_STEP:         cfg_next.max_step         = cfg_wdata[15:0];
                REG_INTEGRATOR_LIMIT: cfg_next.integrator_limit = cfg_wdata[30:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Turning the controller on starts the integral from zero.
    assign integ_clear = cfg_wen && (cfg_index == REG_RUN_ENABLE) && cfg_wdata[0]
                         && !cfg_reg.run_enable;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_enable       <= 1'b0;
            cfg_reg.p_gain           <= P_GAIN_RST;
            cfg_reg.i_gain           <= I_GAIN_RST;
            cfg_reg.d_gain           <= D_GAIN_RST;
            cfg_reg.quiet_band       <= QUIET_BAND_RST;
            cfg_reg.max_step         <= MAX_STEP_RST;
            cfg_reg.integrator_limit <= INTEGRATOR_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/apt_serial_mul.sv]
`default_nettype none

// Signed value times unsigned 16-bit operand, shifted right with rounding half
// away from zero. The 16-bit operand is consumed one bit per cycle.
module apt_serial_mul
    import apt_pkg::*;
#(
    parameter int VW    = 32,
    parameter int SHIFT = 16,
    parameter int OW    = 48
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [VW-1:0] a,
    input  wire logic [MULT_BITS-1:0] b,
    output logic                      done,
    output logic signed [OW-1:0]      res
);

    localparam int PW = VW + MULT_BITS;
    localparam int QW = PW + 1 - SHIFT;
    localparam int CW = $clog2(MULT_BITS);
    localparam logic [PW:0] RND = {{(PW + 1 - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};

    mul_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [VW-1:0] mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [QW-1:0] q_reg, q_next;
    logic signed [OW-1:0] res_reg, res_next;

    logic [VW:0]          step_sum;
    logic [PW:0]          rnd_sum;
    logic signed [QW:0]   sq;

    // One shift-add step: add the magnitude when the low multiplier bit is set.
    assign step_sum = {1'b0, prod_reg[PW-1:MULT_BITS]}
                      + (prod_reg[0] ? {1'b0, mag_reg} : {(VW + 1){1'b0}});
    assign rnd_sum  = {1'b0, prod_reg} + RND;
    assign sq       = neg_reg ? -signed'({1'b0, q_reg}) : signed'({1'b0, q_reg});

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        case (state_reg)
            MUL_IDLE: begin
                if (start) begin
                    neg_next   = a[VW-1];
                    mag_next   = a[VW-1] ? VW'(-a) : VW'(a);
                    prod_next  = {{VW{1'b0}}, b};
                    cnt_next   = '0;
                    state_next = MUL_RUN;
                end
            end
            MUL_RUN: begin
                prod_next = {step_sum, prod_reg[MULT_BITS-1:1]};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MULT_BITS - 1)) begin
                    state_next = MUL_RND;
                end
            end
            MUL_RND: begin
                q_next     = rnd_sum[PW:SHIFT];
                state_next = MUL_SGN;
            end
            MUL_SGN: begin
                res_next   = OW'(sq);
                done_next  = 1'b1;
                state_next = MUL_IDLE;
            end
            default: state_next = MUL_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

[rtl/altitude_pid_thrust_core.sv]
`default_nettype none

// Altitude-hold PID controller: one Q0.16 thrust word per input word. While
// run_enable is clear each word is answered with hover thrust 0.5 through
// ST_OUT and the output register, and the block then returns to idle for the
// next word. While enabled a word passes the states from ST_PREP to ST_OUT
// before the block returns to idle for the next word: the error-times-time-step,
// P and D products run together on bit-serial multipliers that consume their
// 16-bit operand one bit per cycle, and the I product, which needs the updated
// integral, follows on a fourth such multiplier. A result that cannot leave
// adds the cycles it waits for the output register. One word is in work at a
// time; a finished result waits in the output register while the next word is
// taken. Configuration writes are taken in any cycle and must only be issued
// while the block is idle.
module altitude_pid_thrust_core
    import apt_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // altitude_target[31:0], altitude_measured[63:32],
    // vertical_velocity[95:64], time_step[111:96]
    input  wire logic [111:0]             s_tdata,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // thrust_command[15:0]
    output logic [15:0]                   m_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic                     cfg_wen,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int W  = WORD_BITS;
    localparam int XW = ((WORD_BITS > 33) ? WORD_BITS : 33) + 8;
    localparam logic signed [XW-1:0] W_MAX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [XW-1:0] W_MIN = ~W_MAX;
    localparam logic signed [XW-1:0] S32_MAX = {{(XW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0] S32_MIN = ~S32_MAX;
    localparam logic signed [XW-1:0] HOVER_X = signed'(XW'(HOVER_Q16));
    localparam logic signed [XW-1:0] TMIN_X  = signed'(XW'(THRUST_MIN_Q16));
    localparam logic signed [XW-1:0] TMAX_X  = signed'(XW'(THRUST_MAX_Q16));

    cfg_t cfg;
    logic integ_clear;

    apt_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cfg         (cfg),
        .integ_clear (integ_clear)
    );

    state_t state_reg, state_next;
    logic   hover_reg, hover_next;
    logic   out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic signed [31:0] ei_reg, ei_next;
    logic signed [31:0] prev_reg, prev_next;

    logic signed [31:0]  target_reg, target_next;
    logic signed [31:0]  measured_reg, measured_next;
    logic signed [31:0]  vel_in_reg, vel_in_next;
    logic [MULT_BITS-1:0] dt_reg, dt_next;
    logic signed [W-1:0] err_reg, err_next;
    logic signed [W-1:0] vel_reg, vel_next;
    logic signed [XW-1:0] ei_sum_reg, ei_sum_next;
    logic signed [XW-1:0] sum_reg, sum_next;
    logic signed [XW-1:0] cmd_reg, cmd_next;

    logic in_accept, out_free;
    logic start_pd, start_i;
    logic p_done, d_done, dt_done, i_done;
    logic signed [XW-1:0] p_res, d_res, dt_res, i_res;

    logic signed [32:0]   diff;
    logic signed [XW-1:0] diff_x, vel_x, err_x, db_x, lim_x, lim_hi, lim_lo, ms_x;
    logic signed [XW-1:0] prev_x, delta, ei_clamped;
    logic signed [31:0]   ei_new;
    logic signed [XW-1:0] thrust_x, prev_sat;
    logic signed [W-1:0]  err_p;
    logic                 in_band;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign start_pd  = (state_reg == ST_START);
    assign start_i   = (state_reg == ST_CLAMP);

    // Error and velocity, saturated to the working word.
    assign diff   = {target_reg[31], target_reg} - {measured_reg[31], measured_reg};
    assign diff_x = XW'(diff);
    assign vel_x  = XW'(vel_in_reg);

    // Dead band applies to the proportional path only.
    assign err_x   = XW'(err_reg);
    assign db_x    = signed'(XW'(cfg.quiet_band));
    assign in_band = (err_x > -db_x) && (err_x < db_x);
    assign err_p   = in_band ? '0 : err_reg;

    // Integral window: the tighter of the configured limit and the word range.
    assign lim_x      = signed'(XW'(cfg.integrator_limit));
    assign lim_hi     = (lim_x < W_MAX) ? lim_x : W_MAX;
    assign lim_lo     = (-lim_x > W_MIN) ? -lim_x : W_MIN;
    assign ei_clamped = (ei_sum_reg < lim_lo) ? lim_lo :
                        (ei_sum_reg > lim_hi) ? lim_hi : ei_sum_reg;
    // The I product starts from the freshly clamped integral.
    assign ei_new     = 32'(ei_clamped);

    // Slew limit against the stored command.
    assign prev_x = XW'(prev_reg);
    assign ms_x   = signed'(XW'(cfg.max_step));
    assign delta  = cmd_reg - prev_x;

    // Stored command saturates to 32 bits; the output takes the thrust window.
    assign prev_sat = (cmd_reg < S32_MIN) ? S32_MIN :
                      (cmd_reg > S32_MAX) ? S32_MAX : cmd_reg;
    assign thrust_x = (cmd_reg < TMIN_X) ? TMIN_X :
                      (cmd_reg > TMAX_X) ? TMAX_X : cmd_reg;

    apt_serial_mul #(.VW(W), .SHIFT(FRAC_BITS), .OW(XW)) u_mul_p (
        .aclk (aclk), .aresetn (aresetn), .start (start_pd),
        .a (err_p), .b (cfg.p_gain), .done (p_done), .res (p_res)
    );

    apt_serial_mul #(.VW(W), .SHIFT(FRAC_BITS), .OW(XW)) u_mul_d (
        .aclk (aclk), .aresetn (aresetn), .start (start_pd),
        .a (vel_reg), .b (cfg.d_gain), .done (d_done), .res (d_res)
    );

    apt_serial_mul #(.VW(W), .SHIFT(MULT_BITS), .OW(XW)) u_mul_dt (
        .aclk (aclk), .aresetn (aresetn), .start (start_pd),
        .a (err_reg), .b (dt_reg), .done (dt_done), .res (dt_res)
    );

    apt_serial_mul #(.VW(32), .SHIFT(FRAC_BITS), .OW(XW)) u_mul_i (
        .aclk (aclk), .aresetn (aresetn), .start (start_i),
        .a (ei_new), .b (cfg.i_gain), .done (i_done), .res (i_res)
    );

    // Controller sequence.
    always_comb begin
        state_next     = state_reg;
        hover_next     = hover_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ei_next        = ei_reg;
        prev_next      = prev_reg;
        target_next    = target_reg;
        measured_next  = measured_reg;
        vel_in_next    = vel_in_reg;
        dt_next        = dt_reg;
        err_next       = err_reg;
        vel_next       = vel_reg;
        ei_sum_next    = ei_sum_reg;
        sum_next       = sum_reg;
        cmd_next       = cmd_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    target_next   = s_tdata[31:0];
                    measured_next = s_tdata[63:32];
                    vel_in_next   = s_tdata[95:64];
                    dt_next       = s_tdata[111:96];
                    hover_next    = !cfg.run_enable;
                    state_next    = cfg.run_enable ? ST_PREP : ST_OUT;
                end
            end
            ST_PREP: begin
                err_next = W'((diff_x < W_MIN) ? W_MIN : (diff_x > W_MAX) ? W_MAX : diff_x);
                vel_next = W'((vel_x < W_MIN) ? W_MIN : (vel_x > W_MAX) ? W_MAX : vel_x);
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (p_done && d_done && dt_done) begin
                    ei_sum_next = XW'(ei_reg) + dt_res;
                    sum_next    = HOVER_X + p_res - d_res;
                    state_next  = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                ei_next    = ei_new;
                state_next = ST_WAIT2;
            end
            ST_WAIT2: begin
                if (i_done) begin
                    cmd_next   = sum_reg + i_res;
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW: begin
                if (delta > ms_x) begin
                    cmd_next = prev_x + ms_x;
                end else if (delta < -ms_x) begin
                    cmd_next = prev_x - ms_x;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (hover_reg) begin
                        out_data_next = HOVER_Q16;
                    end else begin
                        out_data_next = 16'(thrust_x);
                        prev_next     = 32'(prev_sat);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (integ_clear) begin
            ei_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hover_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            ei_reg        <= '0;
            prev_reg      <= 32'(HOVER_Q16);
        end else begin
            state_reg     <= state_next;
            hover_reg     <= hover_next;
            out_valid_reg <= out_valid_next;
            ei_reg        <= ei_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        target_reg   <= target_next;
        measured_reg <= measured_next;
        vel_in_reg   <= vel_in_next;
        dt_reg       <= dt_next;
        err_reg      <= err_next;
        vel_reg      <= vel_next;
        ei_sum_reg   <= ei_sum_next;
        sum_reg      <= sum_next;
        cmd_reg      <= cmd_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
